// File: rtl/tccw_pkg.sv
// Shared constants, types and the color remap for the text console character writer.
`timescale 1ns / 1ps

package tccw_pkg;

   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = COLUMNS * ROWS;
   localparam int ADDR_W  = $clog2(CELLS);

   localparam int X_W     = 7;
   localparam int Y_W     = 5;
   localparam int CHAR_W  = 8;
   localparam int ATTR_W  = 8;
   localparam int CELL_W  = CHAR_W + ATTR_W;
   localparam int RIDX_W  = 11;
   localparam int FG_W    = 4;
   localparam int BG_W    = 5;
   localparam int VGA_W   = 4;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 32;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 5;

   localparam logic [CHAR_W-1:0] CHAR_NUL       = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_SPACE     = 8'h20;

   localparam logic OP_PUT  = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_FG = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BG = 1'b1;

   localparam logic [FG_W-1:0] FG_RESET = 4'd7;
   localparam logic [BG_W-1:0] BG_RESET = 5'd16;
   localparam logic [BG_W-1:0] BG_COLORS = 5'd16;

   typedef struct packed {
      logic [X_W-1:0] x;
      logic [Y_W-1:0] y;
   } cursor_type;

   typedef struct packed {
      cursor_type          nxt;
      logic                wr_en;
      logic [ADDR_W-1:0]   addr;
      logic [CHAR_W-1:0]   chr;
      logic                scroll;
   } step_type;

   // ANSI color order to VGA color order: swap the red and blue bits
   function automatic logic [VGA_W-1:0] ansi_to_vga(input logic [VGA_W-1:0] c);
      logic [VGA_W-1:0] v;
      unique case (c)
         4'd0:  v = 4'd0;
         4'd1:  v = 4'd4;
         4'd2:  v = 4'd2;
         4'd3:  v = 4'd6;
         4'd4:  v = 4'd1;
         4'd5:  v = 4'd5;
         4'd6:  v = 4'd3;
         4'd7:  v = 4'd7;
         4'd8:  v = 4'd8;
         4'd9:  v = 4'd12;
         4'd10: v = 4'd10;
         4'd11: v = 4'd14;
         4'd12: v = 4'd9;
         4'd13: v = 4'd13;
         4'd14: v = 4'd11;
         default: v = 4'd15;
      endcase
      return v;
   endfunction

endpackage

// File: rtl/tccw_cursor_step.sv
// Cursor update and cell placement for one put request.
`timescale 1ns / 1ps

module tccw_cursor_step (
   input  tccw_pkg::cursor_type             cur,
   input  logic [tccw_pkg::CHAR_W-1:0]      chr,
   output tccw_pkg::step_type               step
);

   logic [tccw_pkg::X_W:0]     nx;
   logic [tccw_pkg::Y_W:0]     ny;
   logic [tccw_pkg::X_W-1:0]   px;
   logic [tccw_pkg::ADDR_W-1:0] row_base;

   always_comb begin
      nx = {1'b0, cur.x};
      ny = {1'b0, cur.y};
      px = cur.x;
      step.wr_en = 1'b0;
      step.chr   = chr;
      priority if (chr == tccw_pkg::CHAR_NUL) begin
         nx = {1'b0, cur.x};
      end else if (chr == tccw_pkg::CHAR_NEWLINE) begin
         nx = '0;
         ny = {1'b0, cur.y} + (tccw_pkg::Y_W+1)'(1);
      end else if (chr == tccw_pkg::CHAR_BACKSPACE) begin
         // step back, stop at column zero, blank the cell under the cursor
         if (cur.x != '0) begin
            px = cur.x - tccw_pkg::X_W'(1);
         end
         nx = {1'b0, px};
         step.wr_en = 1'b1;
         step.chr   = tccw_pkg::CHAR_SPACE;
      end else begin
         step.wr_en = 1'b1;
         nx = {1'b0, cur.x} + (tccw_pkg::X_W+1)'(1);
      end

      if (nx >= (tccw_pkg::X_W+1)'(tccw_pkg::COLUMNS)) begin
         nx = '0;
         ny = ny + (tccw_pkg::Y_W+1)'(1);
      end

      step.scroll = (ny >= (tccw_pkg::Y_W+1)'(tccw_pkg::ROWS));
      if (step.scroll) begin
         ny = (tccw_pkg::Y_W+1)'(tccw_pkg::ROWS - 1);
      end

      step.nxt.x = nx[tccw_pkg::X_W-1:0];
      step.nxt.y = ny[tccw_pkg::Y_W-1:0];

      row_base  = tccw_pkg::ADDR_W'(cur.y) * tccw_pkg::ADDR_W'(tccw_pkg::COLUMNS);
      step.addr = row_base + tccw_pkg::ADDR_W'(px);
   end

endmodule

// File: rtl/text_console_char_writer.sv
// Text console character writer: screen store, scroll sequencer and stream ports.
//
//   channel | direction | ports                         | contents
//   req     | in        | req_tvalid/tready/tdata/tuser | tuser: opcode; tdata: char, read index
//   rsp     | out       | rsp_tvalid/tready/tdata       | cell word, cursor column, cursor row
//   csr     | in        | csr_valid/ready/index/data    | 0: foreground, 1: background
//
// A put or a read is taken in the accept state, then the response state loads the
// response register.
// A put that runs off the last row adds a scroll before the response: a copy pass
// moving rows 1 to ROWS-1 up a row, then a pass clearing the last row, one cell per
// cycle over the single write port.
// After reset a clearing pass zeroes all CELLS entries of the screen store; no request
// is taken meanwhile, csr writes are. A stalled response lets one more request in;
// that request waits in the response cycle and holds the request after it.
`timescale 1ns / 1ps

module text_console_char_writer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [7:0] char_code, [18:8] read_index, [23:19] zero
   input  logic [tccw_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [0] opcode
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [15:0] cell_word, [22:16] cursor_column, [27:23] cursor_row, [31:28] zero
   output logic [tccw_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tccw_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tccw_pkg::CSR_DATA_W-1:0]     csr_data
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCROLL,
      ST_FLUSH,
      ST_RESP
   } state_type;

   localparam logic [tccw_pkg::ADDR_W-1:0] LAST_CELL =
      tccw_pkg::ADDR_W'(tccw_pkg::CELLS - 1);
   localparam logic [tccw_pkg::ADDR_W-1:0] SCROLL_END =
      tccw_pkg::ADDR_W'(tccw_pkg::CELLS - tccw_pkg::COLUMNS);

   state_type                            state_ff, state_in;
   logic [tccw_pkg::ADDR_W-1:0]          cnt_ff, cnt_in;
   logic                                 pend_ff, pend_in;
   logic                                 read_ok_ff, read_ok_in;
   tccw_pkg::cursor_type                 cursor_ff, cursor_in;
   logic [tccw_pkg::FG_W-1:0]            fg_ff, fg_in;
   logic [tccw_pkg::BG_W-1:0]            bg_ff, bg_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [tccw_pkg::RSP_DATA_W-1:0]      rsp_data_ff, rsp_data_in;

   logic [tccw_pkg::CELL_W-1:0]          mem [tccw_pkg::CELLS];
   logic [tccw_pkg::CELL_W-1:0]          rd_data_ff;
   logic                                 mem_we;
   logic [tccw_pkg::ADDR_W-1:0]          mem_waddr;
   logic [tccw_pkg::CELL_W-1:0]          mem_wdata;
   logic                                 mem_re;
   logic [tccw_pkg::ADDR_W-1:0]          mem_raddr;

   logic [tccw_pkg::CHAR_W-1:0]          req_char;
   logic [tccw_pkg::RIDX_W-1:0]          req_ridx;
   logic                                 ridx_ok;
   logic [tccw_pkg::ATTR_W-1:0]          attr;
   logic [tccw_pkg::VGA_W-1:0]           bg_vga;
   logic [tccw_pkg::CELL_W-1:0]          rsp_word;
   tccw_pkg::step_type                   step;

   assign req_char = req_tdata[tccw_pkg::CHAR_W-1:0];
   assign req_ridx = req_tdata[tccw_pkg::CHAR_W +: tccw_pkg::RIDX_W];
   assign ridx_ok  = (req_ridx < tccw_pkg::RIDX_W'(tccw_pkg::CELLS));

   // background codes past the table mean black
   assign bg_vga = (bg_ff < tccw_pkg::BG_COLORS) ?
                   tccw_pkg::ansi_to_vga(bg_ff[tccw_pkg::VGA_W-1:0]) : '0;
   assign attr   = {bg_vga, tccw_pkg::ansi_to_vga(fg_ff)};

   tccw_cursor_step u_step (
      .cur  (cursor_ff),
      .chr  (req_char),
      .step (step)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_word   = read_ok_ff ? rd_data_ff : '0;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pend_in      = 1'b0;
      read_ok_in   = read_ok_ff;
      cursor_in    = cursor_ff;
      fg_in        = fg_ff;
      bg_in        = bg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = cnt_ff;
      mem_wdata    = '0;
      mem_re       = 1'b0;
      mem_raddr    = cnt_ff + tccw_pkg::ADDR_W'(tccw_pkg::COLUMNS);

      if (csr_valid) begin
         unique case (csr_index)
            tccw_pkg::CSR_FG: fg_in = csr_data[tccw_pkg::FG_W-1:0];
            tccw_pkg::CSR_BG: bg_in = csr_data;
            default:          fg_in = fg_ff;
         endcase
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            if (cnt_ff == LAST_CELL) begin
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + tccw_pkg::ADDR_W'(1);
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == tccw_pkg::OP_READ) begin
                  mem_re     = ridx_ok;
                  mem_raddr  = req_ridx[tccw_pkg::ADDR_W-1:0];
                  read_ok_in = ridx_ok;
                  state_in   = ST_RESP;
               end else begin
                  cursor_in  = step.nxt;
                  mem_we     = step.wr_en;
                  mem_waddr  = step.addr;
                  mem_wdata  = {attr, step.chr};
                  read_ok_in = 1'b0;
                  cnt_in     = '0;
                  state_in   = step.scroll ? ST_SCROLL : ST_RESP;
               end
            end
         end
         ST_SCROLL: begin
            // copy one cell up a row: read ahead, write the previous read
            if (pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = cnt_ff - tccw_pkg::ADDR_W'(1);
               mem_wdata = rd_data_ff;
            end
            if (cnt_ff != SCROLL_END) begin
               mem_re  = 1'b1;
               pend_in = 1'b1;
               cnt_in  = cnt_ff + tccw_pkg::ADDR_W'(1);
            end else begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            mem_we = 1'b1;
            if (cnt_ff == LAST_CELL) begin
               state_in = ST_RESP;
            end else begin
               cnt_in = cnt_ff + tccw_pkg::ADDR_W'(1);
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = tccw_pkg::RSP_DATA_W'({cursor_ff.y, cursor_ff.x, rsp_word});
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         read_ok_ff   <= 1'b0;
         cursor_ff    <= '0;
         fg_ff        <= tccw_pkg::FG_RESET;
         bg_ff        <= tccw_pkg::BG_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         read_ok_ff   <= read_ok_in;
         cursor_ff    <= cursor_in;
         fg_ff        <= fg_in;
         bg_ff        <= bg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

endmodule
